/* rtl/core/lut3d_pkg.sv */
// shared types and constants of the 3d lut trilinear color mapper
// no dependencies; imported by lut3d_ctrl, lut3d_datapath and the top level
package lut3d_pkg;

  // lattice and table geometry
  localparam int unsigned MaxGridPoints = 17;
  localparam int unsigned MinGridPoints = 2;
  localparam int unsigned GridReset     = 17;
  localparam int unsigned TableDepth    = MaxGridPoints * MaxGridPoints * MaxGridPoints;
  localparam int unsigned IdxW          = $clog2(MaxGridPoints);
  localparam int unsigned AddrW         = $clog2(TableDepth);
  localparam int unsigned GridW         = 5;

  // value formats: signed 1.16 samples, 16-bit fractions
  localparam int unsigned ValW    = 18;
  localparam int unsigned FracW   = 16;
  localparam int unsigned CornerW = 3;
  localparam int unsigned NumCh   = 3;

  // request opcodes
  localparam logic OpWrite = 1'b0;
  localparam logic OpPixel = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StBase,
    StRead,
    StWait,
    StLerpG0,
    StLerpG1,
    StFinish
  } ctrl_state_e;

  // operand selection of the per-channel interpolation lanes
  typedef enum logic [1:0] {
    StepB,
    StepG0,
    StepG1,
    StepR
  } lerp_step_e;

  typedef struct packed {
    logic               wr_en;
    logic               load;
    logic               base;
    logic               rd_en;
    logic [CornerW-1:0] corner;
    lerp_step_e         step;
    logic               out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/core/lut3d_ctrl.sv */
// sequencer of the 3d lut color mapper: accepts requests, walks the eight
// corner reads and the green and red interpolation steps; uses lut3d_pkg
module lut3d_ctrl import lut3d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       opcode_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e        state_q, state_d;
  logic [CornerW-1:0] corner_q, corner_d;

  // state and corner counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      corner_q <= '0;
    end else begin
      state_q  <= state_d;
      corner_q <= corner_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d      = state_q;
    corner_d     = corner_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.step   = StepB;
    cmd_o.corner = corner_q;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (opcode_i == OpPixel) begin
            cmd_o.load = 1'b1;
            state_d    = StBase;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      StBase: begin
        cmd_o.base = 1'b1;
        corner_d   = '0;
        state_d    = StRead;
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        corner_d    = corner_q + 1'b1;
        if (corner_q == '1) begin
          state_d = StWait;
        end
      end
      StWait: begin
        state_d = StLerpG0;
      end
      StLerpG0: begin
        cmd_o.step = StepG0;
        state_d    = StLerpG1;
      end
      StLerpG1: begin
        cmd_o.step = StepG1;
        state_d    = StFinish;
      end
      StFinish: begin
        cmd_o.step = StepR;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

/* rtl/core/lut3d_datapath.sv */
// datapath of the 3d lut color mapper: grid register, lattice split, table
// memory, three interpolation lanes and the result register; uses lut3d_pkg
module lut3d_datapath import lut3d_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_status_t             status_o,
  input  logic                   cfg_valid_i,
  input  logic [GridW-1:0]       cfg_data_i,
  input  logic [AddrW-1:0]       entry_address_i,
  input  logic signed [ValW-1:0] entry_red_i,
  input  logic signed [ValW-1:0] entry_green_i,
  input  logic signed [ValW-1:0] entry_blue_i,
  input  logic signed [ValW-1:0] pixel_red_i,
  input  logic signed [ValW-1:0] pixel_green_i,
  input  logic signed [ValW-1:0] pixel_blue_i,
  input  logic signed [ValW-1:0] pixel_alpha_i,
  input  logic                   pixel_last_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic signed [ValW-1:0] out_red_o,
  output logic signed [ValW-1:0] out_green_o,
  output logic signed [ValW-1:0] out_blue_o,
  output logic signed [ValW-1:0] out_alpha_o,
  output logic                   out_last_o
);

  localparam int unsigned AccW  = ValW + FracW + 3;
  localparam int unsigned ResW  = ValW + 3;
  localparam int unsigned ScalW = FracW + 1 + GridW;
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(1) <<< (FracW - 1);
  localparam logic signed [ResW-1:0] SatMax = (ResW'(1) <<< (ValW - 1)) - ResW'(1);
  localparam logic signed [ResW-1:0] SatMin = -(ResW'(1) <<< (ValW - 1));
  localparam logic [FracW:0] OneFix = (FracW + 1)'(1) << FracW;

  // a*(1-f)+b*f as a + (b-a)*f, rounded half up, saturated to the field
  function automatic logic signed [ValW-1:0] lerp_fix(
    input logic signed [ValW-1:0] a,
    input logic signed [ValW-1:0] b,
    input logic [FracW-1:0]       f
  );
    logic signed [ValW:0]      diff;
    logic signed [AccW-2:0]    prod;
    logic signed [AccW-1:0]    acc;
    logic signed [ResW-1:0]    res;
    logic signed [ValW-1:0]    sat;
    diff = (ValW + 1)'(b) - (ValW + 1)'(a);
    prod = diff * $signed({1'b0, f});
    acc  = (AccW'(a) <<< FracW) + AccW'(prod) + RoundHalf;
    res  = $signed(acc[AccW-1 -: ResW]);
    if (res > SatMax) begin
      sat = ValW'(SatMax);
    end else if (res < SatMin) begin
      sat = ValW'(SatMin);
    end else begin
      sat = ValW'(res);
    end
    return sat;
  endfunction

  logic [GridW-1:0]       grid_q;
  logic [GridW-1:0]       grid_n;
  logic [2*GridW-1:0]     n2_q;
  logic [IdxW-1:0]        lo_d [NumCh];
  logic [IdxW-1:0]        hi_d [NumCh];
  logic [FracW-1:0]       fr_d [NumCh];
  logic [IdxW-1:0]        lo_q [NumCh];
  logic [IdxW-1:0]        hi_q [NumCh];
  logic [FracW-1:0]       fr_q [NumCh];
  logic signed [ValW-1:0] px [NumCh];
  logic [AddrW-1:0]       ar_q [2];
  logic [AddrW-1:0]       ag_q [2];
  logic [IdxW-1:0]        b_sel;
  logic [AddrW-1:0]       rd_addr;
  logic [NumCh*ValW-1:0]  table_q [TableDepth];
  logic [NumCh*ValW-1:0]  rd_data_q;
  logic                   rd_vld_q;
  logic [CornerW-1:0]     rd_idx_q;
  logic signed [ValW-1:0] rd_ch [NumCh];
  logic signed [ValW-1:0] even_q [NumCh];
  logic signed [ValW-1:0] vg_q [4][NumCh];
  logic signed [ValW-1:0] vr_q [2][NumCh];
  logic signed [ValW-1:0] lerp_res [NumCh];
  logic signed [ValW-1:0] alpha_q;
  logic                   last_q;
  logic                   out_valid_q;
  logic signed [ValW-1:0] out_red_q, out_green_q, out_blue_q, out_alpha_q;
  logic                   out_last_q;

  // grid points register and its clamped value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GridW'(GridReset);
    end else if (cfg_valid_i) begin
      grid_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (grid_q < GridW'(MinGridPoints)) begin
      grid_n = GridW'(MinGridPoints);
    end else if (grid_q > GridW'(MaxGridPoints)) begin
      grid_n = GridW'(MaxGridPoints);
    end else begin
      grid_n = grid_q;
    end
  end

  // clamp each channel to [0,1], scale by n-1, split into corners and fraction
  assign px[0] = pixel_red_i;
  assign px[1] = pixel_green_i;
  assign px[2] = pixel_blue_i;

  always_comb begin
    logic [FracW:0]       v;
    logic [ScalW-1:0]     scaled;
    logic [IdxW:0]        up;
    for (int ch = 0; ch < NumCh; ch++) begin
      if (px[ch] < 0) begin
        v = '0;
      end else if (px[ch] > $signed({1'b0, OneFix})) begin
        v = OneFix;
      end else begin
        v = px[ch][FracW:0];
      end
      scaled    = ScalW'(v) * ScalW'(grid_n - GridW'(1));
      lo_d[ch]  = scaled[FracW +: IdxW];
      fr_d[ch]  = scaled[FracW-1:0];
      up        = (IdxW + 1)'(lo_d[ch]) + (IdxW + 1)'(1);
      hi_d[ch]  = ((IdxW + 1)'(grid_n) > up) ? IdxW'(up) : IdxW'(grid_n - GridW'(1));
    end
  end

  // per-pixel operand registers and address bases
  always_ff @(posedge clk_i) begin
    n2_q <= grid_n * grid_n;
    if (cmd_i.load) begin
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      fr_q    <= fr_d;
      alpha_q <= pixel_alpha_i;
      last_q  <= pixel_last_i;
    end
    if (cmd_i.base) begin
      ar_q[0] <= AddrW'(lo_q[0] * n2_q);
      ar_q[1] <= AddrW'(hi_q[0] * n2_q);
      ag_q[0] <= AddrW'(lo_q[1] * grid_n);
      ag_q[1] <= AddrW'(hi_q[1] * grid_n);
    end
  end

  // corner address, red major and blue minor
  assign b_sel   = cmd_i.corner[0] ? hi_q[2] : lo_q[2];
  assign rd_addr = ar_q[cmd_i.corner[2]] + ag_q[cmd_i.corner[1]] + AddrW'(b_sel);

  // single-port table memory with registered read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && (entry_address_i < AddrW'(TableDepth))) begin
      table_q[entry_address_i] <= {entry_red_i, entry_green_i, entry_blue_i};
    end else if (cmd_i.rd_en) begin
      rd_data_q <= table_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      rd_idx_q <= cmd_i.corner;
    end
  end

  // interpolation lanes, one per color channel
  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      rd_ch[ch] = $signed(rd_data_q[(NumCh - 1 - ch) * ValW +: ValW]);
      unique case (cmd_i.step)
        StepG0:  lerp_res[ch] = lerp_fix(vg_q[0][ch], vg_q[1][ch], fr_q[1]);
        StepG1:  lerp_res[ch] = lerp_fix(vg_q[2][ch], vg_q[3][ch], fr_q[1]);
        StepR:   lerp_res[ch] = lerp_fix(vr_q[0][ch], vr_q[1][ch], fr_q[0]);
        default: lerp_res[ch] = lerp_fix(even_q[ch], rd_ch[ch], fr_q[2]);
      endcase
    end
  end

  // blue pairs as corners arrive, then green and red steps
  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < NumCh; ch++) begin
      if (rd_vld_q && !rd_idx_q[0]) begin
        even_q[ch] <= rd_ch[ch];
      end
      if (rd_vld_q && rd_idx_q[0]) begin
        vg_q[rd_idx_q[2:1]][ch] <= lerp_res[ch];
      end
      if (cmd_i.step == StepG0) begin
        vr_q[0][ch] <= lerp_res[ch];
      end
      if (cmd_i.step == StepG1) begin
        vr_q[1][ch] <= lerp_res[ch];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_red_q   <= lerp_res[0];
      out_green_q <= lerp_res[1];
      out_blue_q  <= lerp_res[2];
      out_alpha_q <= alpha_q;
      out_last_q  <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_red_q;
  assign out_green_o = out_green_q;
  assign out_blue_o  = out_blue_q;
  assign out_alpha_o = out_alpha_q;
  assign out_last_o  = out_last_q;

endmodule

/* rtl/core/lut3d_trilinear_color_map.sv */
// Color grading through a 3d lookup table of up to 17x17x17 RGB entries,
// interpolated trilinearly in signed 1.16. A table write request (opcode 0)
// is written at the accept edge; an address at or beyond 4913 is dropped.
// A pixel request (opcode 1) holds the input from its accept edge to the
// next accept while it passes through the address bases, eight reads of the
// single-port table memory (one corner each), a wait for the last read data
// and the two green and one red interpolation steps; the eight serial corner
// reads take most of that time. The result sits in an output register, so a
// new request is taken while it waits; a second pixel stalls only in its
// final step if the first result is still not taken. Table contents are
// undefined until written, so every entry a pixel touches must be loaded
// first. grid_points is written through the cfg channel (always ready) and
// must be changed only while no pixel is in flight.
// depends on lut3d_pkg, lut3d_ctrl and lut3d_datapath
module lut3d_trilinear_color_map import lut3d_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [GridW-1:0]       cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   opcode_i,
  input  logic [AddrW-1:0]       entry_address_i,
  input  logic signed [ValW-1:0] entry_red_i,
  input  logic signed [ValW-1:0] entry_green_i,
  input  logic signed [ValW-1:0] entry_blue_i,
  input  logic signed [ValW-1:0] pixel_red_i,
  input  logic signed [ValW-1:0] pixel_green_i,
  input  logic signed [ValW-1:0] pixel_blue_i,
  input  logic signed [ValW-1:0] pixel_alpha_i,
  input  logic                   pixel_last_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [ValW-1:0] out_red_o,
  output logic signed [ValW-1:0] out_green_o,
  output logic signed [ValW-1:0] out_blue_o,
  output logic signed [ValW-1:0] out_alpha_o,
  output logic                   out_last_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  // sequencer
  lut3d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // table, interpolation lanes and result register
  lut3d_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .entry_address_i (entry_address_i),
    .entry_red_i     (entry_red_i),
    .entry_green_i   (entry_green_i),
    .entry_blue_i    (entry_blue_i),
    .pixel_red_i     (pixel_red_i),
    .pixel_green_i   (pixel_green_i),
    .pixel_blue_i    (pixel_blue_i),
    .pixel_alpha_i   (pixel_alpha_i),
    .pixel_last_i    (pixel_last_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o),
    .out_alpha_o     (out_alpha_o),
    .out_last_o      (out_last_o)
  );

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("result loaded while previous result not taken");

  // a loaded result shows up as valid in the next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("loaded result not presented");

  // the single table port is never written and read together
  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.wr_en && cmd.rd_en))
    else $error("table write and read in the same cycle");

  // an accepted pixel keeps the input closed in the following cycle
  a_pixel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (opcode_i == OpPixel)) |=> !in_ready_o)
    else $error("request accepted while a pixel is in progress");

endmodule
